// ===== hdl/ddodo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddodo_pkg
// Types, constants and helpers for the differential-drive odometry core.
// ----------------------------------------------------------------------------
package ddodo_pkg;

    // CORDIC depth and derived pipeline figures
    localparam int CORDIC_STAGES = 24;
    localparam int DIV_BITS      = 61;   // numerator width of the turn divider
    localparam int QUO_BITS      = 41;   // kept quotient bits, clamp at 2^40
    localparam int MOD_STEPS     = 12;   // compare/subtract steps of the 2*pi reduction
    localparam int V_W           = 43;   // width of the biased angle under reduction
    localparam int LATENCY       = 85 + CORDIC_STAGES;

    localparam logic [31:0] SCALE_RESET = 32'd937016;

    // angle constants, LSB 2^-28 rad
    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam logic [30:0] PI_FLOOR   = TWO_PI_Q28 / 2;
    localparam logic signed [31:0] TWO_PI_S  = 32'sd1686629713;
    localparam logic signed [31:0] PI_S      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_S = 32'sd421657428;
    localparam logic signed [47:0] MOD_BIAS  = 48'sd3454217652224; // 2*pi << 11
    localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;

    // fields that ride along the whole pipeline
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] h;
        logic [15:0]        rr;
        logic [15:0]        rl;
        logic [17:0]        base;
    } t_carry;

    // divider stage
    typedef struct packed {
        t_carry              c;
        logic                bz;
        logic                s_neg;
        logic [32:0]         s_mag;
        logic                d_neg;
        logic [DIV_BITS-1:0] num;
        logic [17:0]         rem;
        logic [QUO_BITS-1:0] quo;
        logic                ovf;
    } t_div;

    // signed turn
    typedef struct packed {
        t_carry             c;
        logic               bz;
        logic               s_neg;
        logic [32:0]        s_mag;
        logic signed [41:0] t;
    } t_turn;

    // angle reduction stage
    typedef struct packed {
        t_carry             c;
        logic               bz;
        logic               s_neg;
        logic [32:0]        s_mag;
        logic signed [31:0] nh;
        logic [V_W-1:0]     v;
    } t_mod;

    // CORDIC stage
    typedef struct packed {
        t_carry             c;
        logic               bz;
        logic               s_neg;
        logic [32:0]        s_mag;
        logic signed [31:0] nh;
        logic               neg;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [31:0] z;
    } t_cor;

    // magnitudes ahead of the final multiply
    typedef struct packed {
        t_carry             c;
        logic               bz;
        logic signed [31:0] nh;
        logic [32:0]        s_mag;
        logic               xn;
        logic               yn;
        logic [31:0]        xm;
        logic [31:0]        ym;
    } t_fin;

    // partial products
    typedef struct packed {
        t_carry             c;
        logic               bz;
        logic signed [31:0] nh;
        logic               xn;
        logic               yn;
        logic [48:0]        xh;
        logic [47:0]        xl;
        logic [48:0]        yh;
        logic [47:0]        yl;
    } t_prod;

    // rounded position deltas
    typedef struct packed {
        t_carry             c;
        logic               bz;
        logic signed [31:0] nh;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
    } t_rnd;

    // arctangent of 2^-i, LSB 2^-28 rad
    function automatic logic signed [31:0] atan_q28(input int idx);
        logic signed [31:0] a;
        unique case (idx)
            0:  a = 32'sd210828714;
            1:  a = 32'sd124459457;
            2:  a = 32'sd65760959;
            3:  a = 32'sd33381290;
            4:  a = 32'sd16755422;
            5:  a = 32'sd8385879;
            6:  a = 32'sd4193963;
            7:  a = 32'sd2097109;
            8:  a = 32'sd1048571;
            9:  a = 32'sd524287;
            10: a = 32'sd262144;
            11: a = 32'sd131072;
            12: a = 32'sd65536;
            13: a = 32'sd32768;
            14: a = 32'sd16384;
            15: a = 32'sd8192;
            16: a = 32'sd4096;
            17: a = 32'sd2048;
            18: a = 32'sd1024;
            19: a = 32'sd512;
            20: a = 32'sd256;
            21: a = 32'sd128;
            22: a = 32'sd64;
            23: a = 32'sd32;
            24: a = 32'sd16;
            25: a = 32'sd8;
            26: a = 32'sd4;
            27: a = 32'sd2;
            28: a = 32'sd1;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/diff_drive_odometry_update_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_update_core
// Fixed-point differential-drive pose update: distance and turn from encoder
// ticks, pipelined turn divider, 2*pi reduction, unrolled CORDIC, saturation.
// ----------------------------------------------------------------------------
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-----------------------
//  item in   | i_x_position .. i_left_noise           | start && !busy
//  result    | o_next_x .. o_base_zero_error          | o_result_valid, 1 cycle
//  config    | i_cfg_wdata (distance_scale)           | i_cfg_we
//
//  One item per cycle, every cycle; busy is always low.
//  Most of the pipeline depth lies in the 61-step restoring divider for the turn,
//  the 12-step angle reduction and the CORDIC stages.
//  Synchronous active-low reset clears the valid chain and loads the scale.
//  The pipeline never stalls; the receiver takes each result as it appears.
// ----------------------------------------------------------------------------
module diff_drive_odometry_update_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_x_position,
    input  logic signed [31:0] i_y_position,
    input  logic signed [31:0] i_heading,
    input  logic [15:0]        i_right_radius,
    input  logic [15:0]        i_left_radius,
    input  logic [17:0]        i_wheel_base,
    input  logic signed [15:0] i_right_ticks,
    input  logic signed [15:0] i_left_ticks,
    input  logic signed [15:0] i_right_noise,
    input  logic signed [15:0] i_left_noise,
    output logic               o_result_valid,
    output logic signed [31:0] o_next_x,
    output logic signed [31:0] o_next_y,
    output logic signed [31:0] o_next_heading,
    output logic [15:0]        o_next_right_radius,
    output logic [15:0]        o_next_left_radius,
    output logic [17:0]        o_next_wheel_base,
    output logic               o_base_zero_error
);
    import ddodo_pkg::*;

    logic [31:0] r_distance_scale;

    // stage 1..3 registers
    logic               r_s1_v, r_s2_v, r_s3_v;
    t_carry             r_s1_c, r_s2_c, r_s3_c;
    logic signed [33:0] r_s1_pr, r_s1_pl;
    logic               r_s2_an, r_s2_dn, r_s3_an, r_s3_dn;
    logic [32:0]        r_s2_am, r_s2_dm;
    logic [48:0]        r_s3_ah, r_s3_al, r_s3_dh, r_s3_dl;

    // long chains
    t_div               r_div [0:DIV_BITS];
    logic [DIV_BITS:0]  r_div_v;
    t_turn              r_turn;
    logic               r_turn_v;
    t_mod               r_mod [0:MOD_STEPS];
    logic [MOD_STEPS:0] r_mod_v;
    t_cor               r_ang;
    logic               r_ang_v;
    t_cor               r_cor [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] r_cor_v;
    t_fin               r_fin;
    t_prod              r_prod;
    t_rnd               r_rnd;
    logic               r_fin_v, r_prod_v, r_rnd_v;

    logic signed [16:0] ur_sum, ul_sum;
    logic signed [34:0] a_sum, d_sum;
    logic [64:0]        pa, pd;
    logic [65:0]        pa_rnd;
    logic [QUO_BITS-1:0] tm;
    logic signed [47:0] h_turn, v_sum;
    logic signed [31:0] f1_ang;
    t_cor               n_ang0;
    logic [64:0]        mx, my;
    logic [65:0]        mx_rnd, my_rnd;
    logic signed [35:0] rx, ry;

    assign busy = 1'b0;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_distance_scale <= i_cfg_wdata;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_div_v  <= '0;
            r_turn_v <= 1'b0;
            r_mod_v  <= '0;
            r_ang_v  <= 1'b0;
            r_cor_v  <= '0;
            r_fin_v  <= 1'b0;
            r_prod_v <= 1'b0;
            r_rnd_v  <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_s1_v   <= start && !busy;
            r_s2_v   <= r_s1_v;
            r_s3_v   <= r_s2_v;
            r_div_v  <= {r_div_v[DIV_BITS-1:0], r_s3_v};
            r_turn_v <= r_div_v[DIV_BITS];
            r_mod_v  <= {r_mod_v[MOD_STEPS-1:0], r_turn_v};
            r_ang_v  <= r_mod_v[MOD_STEPS];
            r_cor_v  <= {r_cor_v[CORDIC_STAGES-1:0], r_ang_v};
            r_fin_v  <= r_cor_v[CORDIC_STAGES];
            r_prod_v <= r_fin_v;
            r_rnd_v  <= r_prod_v;
            o_result_valid <= r_rnd_v;
        end
    end

    // stage 1: noisy counts and per-wheel products
    assign ur_sum = $signed({i_right_ticks[15], i_right_ticks})
                  + $signed({i_right_noise[15], i_right_noise});
    assign ul_sum = $signed({i_left_ticks[15], i_left_ticks})
                  + $signed({i_left_noise[15], i_left_noise});

    always_ff @(posedge i_clk) begin
        r_s1_c  <= '{x: i_x_position, y: i_y_position, h: i_heading,
                     rr: i_right_radius, rl: i_left_radius, base: i_wheel_base};
        r_s1_pr <= $signed({1'b0, i_right_radius}) * ur_sum;
        r_s1_pl <= $signed({1'b0, i_left_radius}) * ul_sum;
    end

    // stage 2: sum, difference and magnitudes
    assign a_sum = 35'(r_s1_pr) + 35'(r_s1_pl);
    assign d_sum = 35'(r_s1_pr) - 35'(r_s1_pl);

    always_ff @(posedge i_clk) begin
        r_s2_c  <= r_s1_c;
        r_s2_an <= a_sum[34];
        r_s2_dn <= d_sum[34];
        r_s2_am <= a_sum[34] ? 33'(-a_sum) : a_sum[32:0];
        r_s2_dm <= d_sum[34] ? 33'(-d_sum) : d_sum[32:0];
    end

    // stage 3: scale partial products, 16-bit halves of k
    always_ff @(posedge i_clk) begin
        r_s3_c  <= r_s2_c;
        r_s3_an <= r_s2_an;
        r_s3_dn <= r_s2_dn;
        r_s3_ah <= r_s2_am * r_distance_scale[31:16];
        r_s3_al <= r_s2_am * r_distance_scale[15:0];
        r_s3_dh <= r_s2_dm * r_distance_scale[31:16];
        r_s3_dl <= r_s2_dm * r_distance_scale[15:0];
    end

    // stage 4: full products, s and divider numerator
    assign pa     = {r_s3_ah, 16'b0} + 65'(r_s3_al);
    assign pd     = {r_s3_dh, 16'b0} + 65'(r_s3_dl);
    assign pa_rnd = 66'(pa) + (66'd1 << 32);

    always_ff @(posedge i_clk) begin
        r_div[0].c     <= r_s3_c;
        r_div[0].bz    <= (r_s3_c.base == '0);
        r_div[0].s_neg <= r_s3_an;
        r_div[0].s_mag <= pa_rnd[65:33];
        r_div[0].d_neg <= r_s3_dn;
        r_div[0].num   <= 61'(pd[64:5]) + 61'(r_s3_c.base[17:1]);
        r_div[0].rem   <= '0;
        r_div[0].quo   <= '0;
        r_div[0].ovf   <= 1'b0;
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int NB = DIV_BITS - 1 - j;
        t_div       n_div;
        logic [18:0] trial;
        logic        ge;
        always_comb begin
            trial = {r_div[j].rem, r_div[j].num[NB]};
            ge    = trial >= {1'b0, r_div[j].c.base};
            n_div = r_div[j];
            n_div.rem = ge ? 18'(trial - {1'b0, r_div[j].c.base}) : trial[17:0];
            n_div.quo = {r_div[j].quo[QUO_BITS-2:0], ge};
            n_div.ovf = r_div[j].ovf | (ge && (NB >= QUO_BITS));
        end
        always_ff @(posedge i_clk) begin
            r_div[j+1] <= n_div;
        end
    end

    // clamp and sign the turn; zero base forces no turn
    assign tm = (r_div[DIV_BITS].ovf ||
                 (r_div[DIV_BITS].quo[QUO_BITS-1] && |r_div[DIV_BITS].quo[QUO_BITS-2:0]))
              ? (QUO_BITS'(1) << (QUO_BITS-1)) : r_div[DIV_BITS].quo;

    always_ff @(posedge i_clk) begin
        r_turn.c     <= r_div[DIV_BITS].c;
        r_turn.bz    <= r_div[DIV_BITS].bz;
        r_turn.s_neg <= r_div[DIV_BITS].s_neg;
        r_turn.s_mag <= r_div[DIV_BITS].s_mag;
        if (r_div[DIV_BITS].bz) begin
            r_turn.t <= '0;
        end else if (r_div[DIV_BITS].d_neg) begin
            r_turn.t <= -$signed({1'b0, tm});
        end else begin
            r_turn.t <= $signed({1'b0, tm});
        end
    end

    // new heading and biased angle for the reduction
    assign h_turn = 48'(r_turn.c.h) + (48'(r_turn.t) <<< 1);
    assign v_sum  = 48'(r_turn.c.h) + 48'(r_turn.t) + MOD_BIAS;

    always_ff @(posedge i_clk) begin
        r_mod[0].c     <= r_turn.c;
        r_mod[0].bz    <= r_turn.bz;
        r_mod[0].s_neg <= r_turn.s_neg;
        r_mod[0].s_mag <= r_turn.s_mag;
        r_mod[0].nh    <= sat32(h_turn);
        r_mod[0].v     <= v_sum[V_W-1:0];
    end

    // modulo 2*pi, one shifted compare/subtract per stage
    for (genvar m = 0; m < MOD_STEPS; m++) begin : g_mod
        localparam int SH = MOD_STEPS - 1 - m;
        localparam logic [V_W-1:0] SUB = V_W'(TWO_PI_Q28) << SH;
        t_mod n_mod;
        always_comb begin
            n_mod = r_mod[m];
            if (r_mod[m].v >= SUB) begin
                n_mod.v = r_mod[m].v - SUB;
            end
        end
        always_ff @(posedge i_clk) begin
            r_mod[m+1] <= n_mod;
        end
    end

    // center into [-pi, pi]
    always_comb begin
        f1_ang = $signed({1'b0, r_mod[MOD_STEPS].v[30:0]});
        if (r_mod[MOD_STEPS].v[30:0] > PI_FLOOR) begin
            f1_ang = f1_ang - TWO_PI_S;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang.c     <= r_mod[MOD_STEPS].c;
        r_ang.bz    <= r_mod[MOD_STEPS].bz;
        r_ang.s_neg <= r_mod[MOD_STEPS].s_neg;
        r_ang.s_mag <= r_mod[MOD_STEPS].s_mag;
        r_ang.nh    <= r_mod[MOD_STEPS].nh;
        r_ang.neg   <= 1'b0;
        r_ang.cx    <= '0;
        r_ang.cy    <= '0;
        r_ang.z     <= f1_ang;
    end

    // fold into [-pi/2, pi/2] and seed the CORDIC
    always_comb begin
        n_ang0     = r_ang;
        n_ang0.cx  = GAIN_Q30;
        n_ang0.cy  = '0;
        n_ang0.neg = 1'b0;
        if (r_ang.z > HALF_PI_S) begin
            n_ang0.z   = r_ang.z - PI_S;
            n_ang0.neg = 1'b1;
        end else if (r_ang.z < -HALF_PI_S) begin
            n_ang0.z   = r_ang.z + PI_S;
            n_ang0.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cor[0] <= n_ang0;
    end

    // rotation-mode CORDIC, one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
        t_cor n_cor;
        always_comb begin
            n_cor = r_cor[i];
            if (r_cor[i].z >= 0) begin
                n_cor.cx = r_cor[i].cx - (r_cor[i].cy >>> i);
                n_cor.cy = r_cor[i].cy + (r_cor[i].cx >>> i);
                n_cor.z  = r_cor[i].z - atan_q28(i);
            end else begin
                n_cor.cx = r_cor[i].cx + (r_cor[i].cy >>> i);
                n_cor.cy = r_cor[i].cy - (r_cor[i].cx >>> i);
                n_cor.z  = r_cor[i].z + atan_q28(i);
            end
        end
        always_ff @(posedge i_clk) begin
            r_cor[i+1] <= n_cor;
        end
    end

    // unfold, then product signs and magnitudes
    always_ff @(posedge i_clk) begin
        logic signed [33:0] cx_f, cy_f;
        cx_f = r_cor[CORDIC_STAGES].neg ? -r_cor[CORDIC_STAGES].cx : r_cor[CORDIC_STAGES].cx;
        cy_f = r_cor[CORDIC_STAGES].neg ? -r_cor[CORDIC_STAGES].cy : r_cor[CORDIC_STAGES].cy;
        r_fin.c     <= r_cor[CORDIC_STAGES].c;
        r_fin.bz    <= r_cor[CORDIC_STAGES].bz;
        r_fin.nh    <= r_cor[CORDIC_STAGES].nh;
        r_fin.s_mag <= r_cor[CORDIC_STAGES].s_mag;
        r_fin.xn    <= r_cor[CORDIC_STAGES].s_neg ^ cx_f[33];
        r_fin.yn    <= r_cor[CORDIC_STAGES].s_neg ^ cy_f[33];
        r_fin.xm    <= cx_f[33] ? 32'(-cx_f) : cx_f[31:0];
        r_fin.ym    <= cy_f[33] ? 32'(-cy_f) : cy_f[31:0];
    end

    // s times cos/sin, split on s
    always_ff @(posedge i_clk) begin
        r_prod.c  <= r_fin.c;
        r_prod.bz <= r_fin.bz;
        r_prod.nh <= r_fin.nh;
        r_prod.xn <= r_fin.xn;
        r_prod.yn <= r_fin.yn;
        r_prod.xh <= r_fin.s_mag[32:16] * r_fin.xm;
        r_prod.xl <= r_fin.s_mag[15:0] * r_fin.xm;
        r_prod.yh <= r_fin.s_mag[32:16] * r_fin.ym;
        r_prod.yl <= r_fin.s_mag[15:0] * r_fin.ym;
    end

    // round half away from zero to Q16.16
    assign mx     = {r_prod.xh, 16'b0} + 65'(r_prod.xl);
    assign my     = {r_prod.yh, 16'b0} + 65'(r_prod.yl);
    assign mx_rnd = 66'(mx) + (66'd1 << 29);
    assign my_rnd = 66'(my) + (66'd1 << 29);
    assign rx     = $signed(mx_rnd[65:30]);
    assign ry     = $signed(my_rnd[65:30]);

    always_ff @(posedge i_clk) begin
        r_rnd.c  <= r_prod.c;
        r_rnd.bz <= r_prod.bz;
        r_rnd.nh <= r_prod.nh;
        r_rnd.dx <= r_prod.xn ? -rx : rx;
        r_rnd.dy <= r_prod.yn ? -ry : ry;
    end

    // output register: position update with saturation
    always_ff @(posedge i_clk) begin
        o_next_x            <= sat32(48'(r_rnd.c.x) + 48'(r_rnd.dx));
        o_next_y            <= sat32(48'(r_rnd.c.y) + 48'(r_rnd.dy));
        o_next_heading      <= r_rnd.nh;
        o_next_right_radius <= r_rnd.c.rr;
        o_next_left_radius  <= r_rnd.c.rl;
        o_next_wheel_base   <= r_rnd.c.base;
        o_base_zero_error   <= r_rnd.bz;
    end

    // checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_zero_base_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rnd_v && r_rnd.bz) |-> (r_rnd.nh == r_rnd.c.h))
        else $error("zero wheel base changed the heading");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod_v[MOD_STEPS] |-> (r_mod[MOD_STEPS].v < V_W'(TWO_PI_Q28)))
        else $error("angle reduction out of range");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cor_v[0] |-> (r_cor[0].z <= HALF_PI_S && r_cor[0].z >= -HALF_PI_S))
        else $error("CORDIC input angle not folded");

endmodule
